FILE: hdl/kgit_pkg.sv
// ----------------------------------------------------------------------------
// kgit_pkg
// Shared types and codes for the key-frame group index table.
// ----------------------------------------------------------------------------
package kgit_pkg;

   localparam logic [1:0] REQ_FRAME = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      CMD_FRAME,
      CMD_QUERY,
      CMD_CLEAR,
      CMD_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [30:0]        frame_index;
      logic [31:0]        frame_time;
      logic               key_frame;
      logic [30:0]        latency_limit;
      logic signed [31:0] clear_bound;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRAME,
      ST_QREAD,
      ST_QSCAN,
      ST_CREAD,
      ST_CSCAN,
      ST_DONE
   } back_state_type;

endpackage

FILE: hdl/kgit_front.sv
// ----------------------------------------------------------------------------
// kgit_front
// Accepts request items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module kgit_front
   import kgit_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [30:0]        req_frame_index,
   input  logic [31:0]        req_frame_time,
   input  logic               req_key_frame,
   input  logic [30:0]        req_latency_limit,
   input  logic signed [31:0] req_clear_bound,
   output logic               q_valid,
   output cmd_type            q_cmd,
   input  logic               q_take
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   cmd_type    cmd_new;

   always_comb begin
      cmd_new.frame_index   = req_frame_index;
      cmd_new.frame_time    = req_frame_time;
      cmd_new.key_frame     = req_key_frame;
      cmd_new.latency_limit = req_latency_limit;
      cmd_new.clear_bound   = req_clear_bound;
      case (req_type)
         REQ_FRAME: cmd_new.kind = CMD_FRAME;
         REQ_QUERY: cmd_new.kind = CMD_QUERY;
         REQ_CLEAR: cmd_new.kind = CMD_CLEAR;
         default:   cmd_new.kind = CMD_NONE;
      endcase
   end

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = q_ff[rd_ptr_ff];
   assign pop     = q_take && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

FILE: hdl/kgit_back.sv
// ----------------------------------------------------------------------------
// kgit_back
// Executes queued items: ring insert, statistics, query and clear walks.
// ----------------------------------------------------------------------------
module kgit_back
   import kgit_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int PW          = $clog2(TABLE_DEPTH),
   parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  cmd_type       q_cmd,
   output logic          q_take,
   output logic          rsp_strobe,
   output logic          rsp_found,
   output logic [30:0]   rsp_gop_start_index,
   output logic [31:0]   rsp_gop_age,
   output logic [CW-1:0] rsp_entry_count,
   output logic [31:0]   rsp_longest_gop,
   output logic [47:0]   rsp_total_gop_frames,
   output logic [31:0]   rsp_gop_total_count,
   output logic [31:0]   rsp_newest_time,
   output logic          rsp_overwrite_flag
);

   localparam logic [PW:0]   DEPTH_P = (PW+1)'(TABLE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [47:0]   MAX48   = '1;
   localparam logic [31:0]   MAX32   = '1;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;

   logic [PW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [31:0]   latest_ff, latest_in;
   logic [31:0]   cur_ff, cur_in;
   logic [31:0]   max_ff, max_in;
   logic [47:0]   sum_ff, sum_in;
   logic [31:0]   kcnt_ff, kcnt_in;
   logic          found_ff, found_in;
   logic [30:0]   start_ff, start_in;
   logic [31:0]   age_ff, age_in;
   logic          over_ff, over_in;

   logic [30:0]   idx_mem  [TABLE_DEPTH];
   logic [31:0]   time_mem [TABLE_DEPTH];
   logic [30:0]   rd_idx_ff;
   logic [31:0]   rd_time_ff;
   logic [PW-1:0] rd_addr, wr_addr;
   logic          wr_en;

   logic          strobe_ff;
   logic [48:0]   sum_ext;
   logic [31:0]   age_now;

   function automatic logic [PW-1:0] slot_at(input logic [PW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [PW:0] s;
      s = {1'b0, base} + (PW+1)'(off);
      if (s >= DEPTH_P) begin
         s = s - DEPTH_P;
      end
      return s[PW-1:0];
   endfunction

   assign q_take  = (state_ff == ST_IDLE);
   assign sum_ext = {1'b0, sum_ff} + 49'(cur_ff);
   assign age_now = latest_ff - rd_time_ff;

   always_comb begin
      state_in  = state_ff;
      oldest_in = oldest_ff;
      held_in   = held_ff;
      scan_in   = scan_ff;
      latest_in = latest_ff;
      cur_in    = cur_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      kcnt_in   = kcnt_ff;
      found_in  = found_ff;
      start_in  = start_ff;
      age_in    = age_ff;
      over_in   = over_ff;
      rd_addr   = oldest_ff;
      wr_addr   = oldest_ff;
      wr_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               found_in = 1'b0;
               start_in = '0;
               age_in   = '0;
               over_in  = 1'b0;
               case (q_cmd.kind)
                  CMD_FRAME: state_in = ST_FRAME;
                  CMD_QUERY: state_in = ST_QREAD;
                  CMD_CLEAR: state_in = ST_CREAD;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_FRAME: begin
            latest_in = cmd_ff.frame_time;
            if (cmd_ff.key_frame) begin
               wr_en = 1'b1;
               if (held_ff == DEPTH_C) begin
                  wr_addr   = oldest_ff;
                  oldest_in = slot_at(oldest_ff, CW'(1));
                  over_in   = 1'b1;
               end else begin
                  wr_addr = slot_at(oldest_ff, held_ff);
                  held_in = held_ff + CW'(1);
               end
               if (cur_ff > max_ff) begin
                  max_in = cur_ff;
               end
               sum_in  = sum_ext[48] ? MAX48 : sum_ext[47:0];
               kcnt_in = (kcnt_ff == MAX32) ? kcnt_ff : kcnt_ff + 32'd1;
               cur_in  = 32'd1;
            end else begin
               cur_in = (cur_ff == MAX32) ? cur_ff : cur_ff + 32'd1;
            end
            state_in = ST_DONE;
         end
         ST_QREAD: begin
            if (held_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_addr  = slot_at(oldest_ff, held_ff - CW'(1));
               scan_in  = held_ff;
               state_in = ST_QSCAN;
            end
         end
         ST_QSCAN: begin
            // walk newest to oldest, one entry per cycle
            if (age_now >= {1'b0, cmd_ff.latency_limit}) begin
               state_in = ST_DONE;
            end else begin
               found_in = 1'b1;
               start_in = rd_idx_ff;
               age_in   = age_now;
               if (scan_ff == CW'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  rd_addr = slot_at(oldest_ff, scan_ff - CW'(2));
                  scan_in = scan_ff - CW'(1);
               end
            end
         end
         ST_CREAD: begin
            if (held_ff == '0 || cmd_ff.clear_bound[31]) begin
               state_in = ST_DONE;
            end else begin
               rd_addr  = oldest_ff;
               state_in = ST_CSCAN;
            end
         end
         ST_CSCAN: begin
            if ($signed({1'b0, rd_idx_ff}) > cmd_ff.clear_bound) begin
               state_in = ST_DONE;
            end else begin
               oldest_in = slot_at(oldest_ff, CW'(1));
               held_in   = held_ff - CW'(1);
               rd_addr   = slot_at(oldest_ff, CW'(1));
               if (held_ff == CW'(1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         oldest_ff <= '0;
         held_ff   <= '0;
         latest_ff <= '0;
         cur_ff    <= '0;
         max_ff    <= '0;
         sum_ff    <= '0;
         kcnt_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         held_ff   <= held_in;
         latest_ff <= latest_in;
         cur_ff    <= cur_in;
         max_ff    <= max_in;
         sum_ff    <= sum_in;
         kcnt_ff   <= kcnt_in;
         strobe_ff <= (state_ff == ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      found_ff <= found_in;
      start_ff <= start_in;
      age_ff   <= age_in;
      over_ff  <= over_in;
      if (state_ff == ST_IDLE && q_valid) begin
         cmd_ff <= q_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         idx_mem[wr_addr]  <= cmd_ff.frame_index;
         time_mem[wr_addr] <= cmd_ff.frame_time;
      end
      rd_idx_ff  <= idx_mem[rd_addr];
      rd_time_ff <= time_mem[rd_addr];
   end

   logic [30:0]   rsp_start_ff;
   logic [31:0]   rsp_age_ff;
   logic          rsp_found_ff, rsp_over_ff;
   logic [CW-1:0] rsp_count_ff;
   logic [31:0]   rsp_max_ff, rsp_kcnt_ff, rsp_time_ff;
   logic [47:0]   rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         rsp_found_ff <= found_ff;
         rsp_start_ff <= start_ff;
         rsp_age_ff   <= age_ff;
         rsp_count_ff <= held_ff;
         rsp_max_ff   <= max_ff;
         rsp_sum_ff   <= sum_ff;
         rsp_kcnt_ff  <= kcnt_ff;
         rsp_time_ff  <= latest_ff;
         rsp_over_ff  <= over_ff;
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_gop_start_index  = rsp_start_ff;
   assign rsp_gop_age          = rsp_age_ff;
   assign rsp_entry_count      = rsp_count_ff;
   assign rsp_longest_gop      = rsp_max_ff;
   assign rsp_total_gop_frames = rsp_sum_ff;
   assign rsp_gop_total_count  = rsp_kcnt_ff;
   assign rsp_newest_time      = rsp_time_ff;
   assign rsp_overwrite_flag   = rsp_over_ff;

`ifndef SYNTHESIS
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= DEPTH_C)
      else $error("held count above table depth");
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("back-to-back result strobes");
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rsp_over_ff) |-> (rsp_count_ff == DEPTH_C))
      else $error("overwrite reported on a table that is not full");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_IDLE))
      else $error("done state did not return to idle");
`endif

endmodule

FILE: hdl/keyframe_gop_index_table_unit.sv
// Throughput: one item at a time in the back end; one table entry per cycle is
// read from the ring memory. A 2-item queue lets start be taken during a walk.
// Reset (synchronous): table empty, counters zero; ring memory is not cleared.
// The receiver cannot stall: each result is shown for one cycle on rsp_strobe.
// ----------------------------------------------------------------------------
// keyframe_gop_index_table_unit
// Key-frame group index table: front queue plus executing back end.
// ----------------------------------------------------------------------------
module keyframe_gop_index_table_unit
   import kgit_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [30:0]                       req_frame_index,
   input  logic [31:0]                       req_frame_time,
   input  logic                              req_key_frame,
   input  logic [30:0]                       req_latency_limit,
   input  logic signed [31:0]                req_clear_bound,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [30:0]                       rsp_gop_start_index,
   output logic [31:0]                       rsp_gop_age,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]  rsp_entry_count,
   output logic [31:0]                       rsp_longest_gop,
   output logic [47:0]                       rsp_total_gop_frames,
   output logic [31:0]                       rsp_gop_total_count,
   output logic [31:0]                       rsp_newest_time,
   output logic                              rsp_overwrite_flag
);

   logic    q_valid, q_take;
   cmd_type q_cmd;

   kgit_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_frame_index   (req_frame_index),
      .req_frame_time    (req_frame_time),
      .req_key_frame     (req_key_frame),
      .req_latency_limit (req_latency_limit),
      .req_clear_bound   (req_clear_bound),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .q_take            (q_take)
   );

   kgit_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_cmd                (q_cmd),
      .q_take               (q_take),
      .rsp_strobe           (rsp_strobe),
      .rsp_found            (rsp_found),
      .rsp_gop_start_index  (rsp_gop_start_index),
      .rsp_gop_age          (rsp_gop_age),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_longest_gop      (rsp_longest_gop),
      .rsp_total_gop_frames (rsp_total_gop_frames),
      .rsp_gop_total_count  (rsp_gop_total_count),
      .rsp_newest_time      (rsp_newest_time),
      .rsp_overwrite_flag   (rsp_overwrite_flag)
   );

endmodule
